// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// expects signals named clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SWLCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("swlcd assertion failed");

// condition must never be true outside reset
`define SWLCD_NEVER(lbl, cond) \
  `SWLCD_ASSERT(lbl, !(cond))

`endif

// ===== rtl/core/swlcd_pkg.sv =====
// types and constants of the stopwatch lcd write generator
// no dependencies
`default_nettype none

package swlcd_pkg;

  // field widths
  localparam int MsW       = 23;
  localparam int NumDigits = 6;
  localparam int StepW     = 3;
  localparam int NumWrites = 18;
  localparam int IdxW      = 5;
  localparam int QueueDepth = 2;

  // time limits and digit weights in ms, most significant digit first
  localparam logic [MsW-1:0] MaxMs = 23'd5999999;
  localparam int unsigned Weights [NumDigits] = '{600000, 60000, 10000, 1000, 100, 10};

  // display codes
  localparam logic [7:0] CmdDdram   = 8'h80;
  localparam logic [7:0] Row1Offset = 8'h40;
  localparam logic [7:0] HeaderCol  = 8'h04;
  localparam logic [7:0] CmdRow0    = CmdDdram + HeaderCol;
  localparam logic [7:0] CmdRow1    = CmdDdram + Row1Offset + HeaderCol;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiColon = 8'h3A;
  localparam logic [6:0] SettleCmd  = 7'd50;
  localparam logic [6:0] SettleData = 7'd100;

  typedef struct packed {
    logic [MsW-1:0] total_ms;
    logic           running;
  } in_t;

  typedef struct packed {
    logic       reg_select;
    logic [7:0] lcd_byte;
    logic [6:0] settle_us;
    logic       last;
  } out_t;

  // one converted item waiting for the display sequencer
  typedef struct packed {
    logic                      running;
    logic [NumDigits-1:0][3:0] digits;
  } task_t;

  // queue status seen by the front and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/swlcd_front.sv =====
// front part: accepts a time, saturates it and splits it into six decimal digits
// depends on swlcd_pkg
`default_nettype none

module swlcd_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  swlcd_pkg::in_t   in_data,
  output logic             push,
  input  swlcd_pkg::qstat_t q_status,
  output swlcd_pkg::task_t push_task
);
  import swlcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CONV = 2'b10
  } state_t;

  state_t                    state, state_next;
  logic [StepW-1:0]          step;
  logic [MsW-1:0]            rem;
  logic                      running;
  logic [NumDigits-1:0][3:0] digits;

  logic [MsW-1:0]            mult_tab [NumDigits][10];
  logic [3:0]                digit;
  logic [MsW-1:0]            rem_sub;
  logic                      last_step;
  logic                      advance;
  logic                      accept;

  // constant multiples of each digit weight
  for (genvar s = 0; s < NumDigits; s++) begin : g_tab_s
    for (genvar k = 0; k < 10; k++) begin : g_tab_k
      assign mult_tab[s][k] = MsW'(Weights[s] * k);
    end
  end

  // one digit per cycle, the last held while the queue is full: count the multiples that fit, then subtract
  always_comb begin
    digit = '0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= mult_tab[step][k]) digit = 4'(k);
    end
  end
  assign rem_sub = rem - mult_tab[step][digit];

  // handshake with input and queue
  assign last_step = (step == StepW'(NumDigits - 1));
  assign push      = (state == ST_CONV) && last_step && !q_status.full;
  assign advance   = (state == ST_CONV) && (!last_step || !q_status.full);
  assign in_ready  = (state == ST_IDLE) || push;
  assign accept    = in_valid && in_ready;

  // converted item, last digit taken straight from this cycle
  always_comb begin
    push_task.running = running;
    push_task.digits  = digits;
    push_task.digits[NumDigits-1] = digit;
  end

  // state sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (accept) state_next = ST_CONV;
        else if (push) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rem     <= (in_data.total_ms > MaxMs) ? MaxMs : in_data.total_ms;
      running <= in_data.running;
      step    <= '0;
    end else if (advance) begin
      digits[step] <= digit;
      rem          <= rem_sub;
      step         <= step + StepW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/swlcd_queue.sv =====
// short queue of converted items between the front and the sequencer
// depends on swlcd_pkg
`default_nettype none

module swlcd_queue #(
  parameter int Depth = swlcd_pkg::QueueDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  swlcd_pkg::task_t  push_task,
  input  logic              pop,
  output logic              head_valid,
  output swlcd_pkg::task_t  head,
  output swlcd_pkg::qstat_t status
);
  import swlcd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  task_t             store [Depth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count == CntW'(Depth));
  assign status.empty = (count == '0);
  assign head_valid   = !status.empty;
  assign head         = store[rd_ptr];
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr] <= push_task;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      if (do_push && !do_pop) count <= count + CntW'(1);
      else if (do_pop && !do_push) count <= count - CntW'(1);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/swlcd_back.sv =====
// back part: sequences the eighteen display writes of one converted item
// depends on swlcd_pkg
`default_nettype none

module swlcd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  swlcd_pkg::task_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output swlcd_pkg::out_t  out_data
);
  import swlcd_pkg::*;

  logic [IdxW-1:0] idx;
  logic            advance;
  logic            last_write;
  out_t            write_next;

  // header text, one character per position
  function automatic logic [7:0] header_char(input logic run, input logic [2:0] pos);
    logic [7:0] ch;
    ch = AsciiColon;
    if (run) begin
      unique case (pos)
        3'd0: ch = "R";
        3'd1: ch = "u";
        3'd2: ch = "n";
        3'd3: ch = "n";
        3'd4: ch = "i";
        3'd5: ch = "n";
        3'd6: ch = "g";
        default: ch = AsciiColon;
      endcase
    end else begin
      unique case (pos)
        3'd0: ch = "S";
        3'd1: ch = "t";
        3'd2: ch = "o";
        3'd3: ch = "p";
        3'd4: ch = "p";
        3'd5: ch = "e";
        3'd6: ch = "d";
        default: ch = AsciiColon;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return AsciiZero | {4'b0000, d};
  endfunction

  // write for the current position in the sequence
  always_comb begin
    write_next.reg_select = 1'b1;
    write_next.lcd_byte   = AsciiColon;
    write_next.last       = last_write;
    unique case (idx)
      5'd0: begin
        write_next.reg_select = 1'b0;
        write_next.lcd_byte   = CmdRow0;
      end
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8: begin
        write_next.lcd_byte = header_char(head.running, 3'(idx - IdxW'(1)));
      end
      5'd9: begin
        write_next.reg_select = 1'b0;
        write_next.lcd_byte   = CmdRow1;
      end
      5'd10: write_next.lcd_byte = digit_char(head.digits[0]);
      5'd11: write_next.lcd_byte = digit_char(head.digits[1]);
      5'd13: write_next.lcd_byte = digit_char(head.digits[2]);
      5'd14: write_next.lcd_byte = digit_char(head.digits[3]);
      5'd16: write_next.lcd_byte = digit_char(head.digits[4]);
      5'd17: write_next.lcd_byte = digit_char(head.digits[5]);
      default: write_next.lcd_byte = AsciiColon;
    endcase
    write_next.settle_us = write_next.reg_select ? SettleData : SettleCmd;
  end

  // one write per cycle while the output register can take it
  assign last_write = (idx == IdxW'(NumWrites - 1));
  assign advance    = head_valid && (!out_valid || out_ready);
  assign pop        = advance && last_write;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      idx       <= last_write ? '0 : idx + IdxW'(1);
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (advance) out_data <= write_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/stopwatch_time_to_lcd_writes_top.sv =====
// Stopwatch time to character-LCD writes. Each transaction in carries a time in ms
// (saturated at 99:59.999) and a running flag; it yields eighteen byte writes out:
// cursor command, eight header characters, cursor command, then MM:SS:HH as ASCII,
// with last set on the eighteenth. The front converts a time one decimal digit per
// cycle, holding the last while the queue is full, by a compare-and-subtract against
// constant digit weights, and hands it to a two-entry queue; the sequencer then emits
// one write per cycle while out_ready allows, through a registered output. The front
// takes a new time as it pushes the last one; the output port sets the item rate.
// depends on swlcd_pkg, swlcd_front, swlcd_queue, swlcd_back, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module stopwatch_time_to_lcd_writes_top #(
  parameter int QueueDepth = swlcd_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  swlcd_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output swlcd_pkg::out_t out_data
);
  import swlcd_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_head_valid;
  task_t   q_push_task;
  task_t   q_head;
  qstat_t  q_status;
  logic    out_is_digit;
  logic    out_settle_ok;

  // digit conversion
  swlcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (q_push),
    .q_status  (q_status),
    .push_task (q_push_task)
  );

  // decoupling queue
  swlcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_task  (q_push_task),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head),
    .status     (q_status)
  );

  // write sequencer
  swlcd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // output write classification for the checks
  assign out_is_digit  = out_data.reg_select && (out_data.lcd_byte[7:4] == 4'h3);
  assign out_settle_ok = out_data.reg_select ? (out_data.settle_us == SettleData)
                                             : (out_data.settle_us == SettleCmd);

  // checks
  `SWLCD_NEVER(a_no_push_full, q_push && q_status.full)
  `SWLCD_ASSERT(a_accept_busy, (in_valid && in_ready) |=> !in_ready)
  `SWLCD_ASSERT(a_last_is_digit, (out_valid && out_data.last) |-> out_is_digit)
  `SWLCD_ASSERT(a_settle, out_valid |-> out_settle_ok)

endmodule

`default_nettype wire
